[sv/b58id_pkg.sv]
// ----------------------------------------------------------------------------
// b58id_pkg
// Constants, tables and helpers shared by the base-58 ID codec pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package b58id_pkg;

  localparam int CODE_LEN = 10;
  localparam int RADIX    = 58;
  localparam int ID_W     = 30;
  localparam int CHAR_W   = 8;
  localparam int DIG_W    = 6;
  localparam int LO_DIGS  = 5;
  localparam int TDATA_W  = 112;

  localparam logic [ID_W-1:0] XOR_MASK   = 30'h0A93B324;
  localparam logic [63:0]     ADD_OFFSET = 64'd100618342136696320;
  localparam logic [63:0]     P5         = 64'd656356768;
  localparam logic [ID_W:0]   P5_X1      = 31'(P5);
  localparam logic [ID_W:0]   P5_X2      = 31'(P5 * 64'd2);
  localparam logic [ID_W-1:0] OFF_LO5    = 30'(ADD_OFFSET % P5);
  localparam logic [63:0]     OFF_HI5    = ADD_OFFSET / P5;
  localparam logic [ID_W-1:0] OFF_LO30   = ADD_OFFSET[ID_W-1:0];

  // floor(n / 58) == (n * RECIP58) >> 36 for every n below 2^30
  localparam logic [30:0] RECIP58 = 31'd1184818565;

  localparam logic [3:0] POS_POWER [CODE_LEN] = '{
    4'd6, 4'd2, 4'd4, 4'd8, 4'd5, 4'd9, 4'd3, 4'd7, 4'd1, 4'd0
  };

  localparam logic [CHAR_W-1:0] SYMBOLS [RADIX] = '{
    "1","2","3","4","5","6","7","8","9","A","B","C","D","E","F","G","H","J",
    "K","L","M","N","P","Q","R","S","T","U","V","W","X","Y","Z","a","b","c",
    "d","e","f","g","h","i","j","k","m","n","o","p","q","r","s","t","u","v",
    "w","x","y","z"
  };

  localparam logic [DIG_W-1:0] SYMBOL_VALUE [RADIX] = '{
    6'd13, 6'd12, 6'd46, 6'd31, 6'd43, 6'd18, 6'd40, 6'd28, 6'd5,  6'd54,
    6'd20, 6'd15, 6'd8,  6'd39, 6'd57, 6'd45, 6'd36, 6'd38, 6'd51, 6'd42,
    6'd49, 6'd52, 6'd53, 6'd7,  6'd4,  6'd9,  6'd50, 6'd10, 6'd44, 6'd34,
    6'd6,  6'd25, 6'd1,  6'd26, 6'd29, 6'd56, 6'd3,  6'd24, 6'd0,  6'd47,
    6'd27, 6'd22, 6'd41, 6'd16, 6'd11, 6'd37, 6'd2,  6'd35, 6'd21, 6'd17,
    6'd33, 6'd30, 6'd48, 6'd23, 6'd55, 6'd32, 6'd14, 6'd19
  };

  typedef struct packed {
    logic                           func;
    logic [1:0]                     hq;
    logic [LO_DIGS-1:0][DIG_W-1:0]  dig;
    logic [ID_W-1:0]                number;
    logic                           bad;
  } b58id_mid_t;

  function automatic logic [CHAR_W-1:0] sym_of_val(input logic [DIG_W-1:0] v);
    logic [CHAR_W-1:0] s;
    s = '0;
    for (int i = 0; i < RADIX; i++) begin
      if (SYMBOL_VALUE[i] == v) s = SYMBOLS[i];
    end
    return s;
  endfunction

  function automatic logic [DIG_W-1:0] char_value(input logic [CHAR_W-1:0] c);
    logic [DIG_W-1:0] v;
    v = '0;
    for (int i = 0; i < RADIX; i++) begin
      if (SYMBOLS[i] == c) v = SYMBOL_VALUE[i];
    end
    return v;
  endfunction

  function automatic logic char_known(input logic [CHAR_W-1:0] c);
    logic k;
    k = 1'b0;
    for (int i = 0; i < RADIX; i++) begin
      if (SYMBOLS[i] == c) k = 1'b1;
    end
    return k;
  endfunction

  function automatic logic [24:0] div58(input logic [ID_W-1:0] n);
    logic [60:0] p;
    p = 61'(n) * 61'(RECIP58);
    return p[60:36];
  endfunction

  function automatic logic [DIG_W-1:0] rem58(input logic [ID_W-1:0] n,
                                             input logic [24:0] q);
    logic [ID_W-1:0] t;
    t = n - 30'(q) * 30'd58;
    return t[DIG_W-1:0];
  endfunction

  function automatic logic [ID_W-1:0] pos_weight(input int p);
    logic [63:0] r;
    r = 64'd1;
    for (int i = 0; i < CODE_LEN; i++) begin
      if (i < int'(POS_POWER[p])) r = r * 64'd58;
    end
    return r[ID_W-1:0];
  endfunction

  function automatic logic [CHAR_W-1:0] hi_sym(input int q, input int j);
    logic [63:0] v;
    v = OFF_HI5 + 64'(q);
    for (int i = 0; i < LO_DIGS; i++) begin
      if (i < j) v = v / 64'd58;
    end
    return sym_of_val(6'(v % 64'd58));
  endfunction

  localparam logic [ID_W-1:0] POS_WEIGHT [CODE_LEN] = '{
    pos_weight(0), pos_weight(1), pos_weight(2), pos_weight(3), pos_weight(4),
    pos_weight(5), pos_weight(6), pos_weight(7), pos_weight(8), pos_weight(9)
  };

  // symbols of the upper five digits, by carry out of the lower five
  localparam logic [CHAR_W-1:0] HI_SYM [4][LO_DIGS] = '{
    '{hi_sym(0, 0), hi_sym(0, 1), hi_sym(0, 2), hi_sym(0, 3), hi_sym(0, 4)},
    '{hi_sym(1, 0), hi_sym(1, 1), hi_sym(1, 2), hi_sym(1, 3), hi_sym(1, 4)},
    '{hi_sym(2, 0), hi_sym(2, 1), hi_sym(2, 2), hi_sym(2, 3), hi_sym(2, 4)},
    '{hi_sym(3, 0), hi_sym(3, 1), hi_sym(3, 2), hi_sym(3, 3), hi_sym(3, 4)}
  };

endpackage

`default_nettype wire

[sv/b58id_out_stage.sv]
// ----------------------------------------------------------------------------
// b58id_out_stage
// Final stage: digit permutation, symbol mapping and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module b58id_out_stage import b58id_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               mid_valid_i,
  output logic                    mid_ready_o,
  input  wire b58id_mid_t         mid_i,
  output logic                    m_axis_tvalid_o,
  input  wire logic               m_axis_tready_i,
  // result_number[29:0], out_char_0..out_char_9 [109:30], zero [111:110]
  output logic [TDATA_W-1:0]      m_axis_tdata_o,
  // bad_symbol
  output logic                    m_axis_tuser_o
);

  logic                 valid_q;
  logic [TDATA_W-1:0]   tdata_d, tdata_q;
  logic                 tuser_d, tuser_q;

  always_comb begin
    logic [CHAR_W-1:0] ch;
    logic [3:0]        k;
    tdata_d = '0;
    tdata_d[ID_W-1:0] = mid_i.func ? mid_i.number : '0;
    for (int p = 0; p < CODE_LEN; p++) begin
      k = POS_POWER[p];
      if (k < 4'(LO_DIGS)) begin
        ch = sym_of_val(mid_i.dig[k[2:0]]);
      end else begin
        ch = HI_SYM[mid_i.hq][3'(k - 4'(LO_DIGS))];
      end
      tdata_d[ID_W + CHAR_W*p +: CHAR_W] = mid_i.func ? '0 : ch;
    end
    tuser_d = mid_i.func & mid_i.bad;
  end

  assign mid_ready_o = !valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (mid_ready_o) begin
      valid_q <= mid_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mid_ready_o && mid_valid_i) begin
      tdata_q <= tdata_d;
      tuser_q <= tuser_d;
    end
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = tdata_q;
  assign m_axis_tuser_o  = tuser_q;

endmodule

`default_nettype wire

[sv/base58_permuted_id_codec_core.sv]
// ----------------------------------------------------------------------------
// base58_permuted_id_codec_core
// Numeric ID <-> ten-character base-58 code, pipelined in both directions.
// ----------------------------------------------------------------------------
// channel   dir  tdata                                   tuser
// s_axis    in   id_number[29:0], code_char_0..9 [109:30] func
// m_axis    out  result_number[29:0], out_char_0..9       bad_symbol
//
// One transfer per cycle, in either direction, while m_axis is not stalled.
// The depth is set by the chain of divide-by-58 stages (one reciprocal
// multiply each) that peel off the five low digits; the upper five come
// from a table indexed by the carry out of the low part.
// Reset clears the stage valid bits only. Each stage stalls on its own, so
// bubbles close up behind a stalled output.
// ----------------------------------------------------------------------------
`default_nettype none

module base58_permuted_id_codec_core import b58id_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  // id_number[29:0], code_char_0..code_char_9 [109:30], zero [111:110]
  input  wire logic [TDATA_W-1:0] s_axis_tdata_i,
  // func
  input  wire logic               s_axis_tuser_i,
  output logic                    m_axis_tvalid_o,
  input  wire logic               m_axis_tready_i,
  // result_number[29:0], out_char_0..out_char_9 [109:30], zero [111:110]
  output logic [TDATA_W-1:0]      m_axis_tdata_o,
  // bad_symbol
  output logic                    m_axis_tuser_o
);

  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, out_rdy;

  assign rdy5 = !v5_q || out_rdy;
  assign rdy4 = !v4_q || rdy5;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign s_axis_tready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
      if (rdy5) v5_q <= v4_q;
    end
  end

  // stage 1: mask, add low offset, split carry; character lookup
  logic                         f1_q, bad1_d, bad1_q;
  logic [1:0]                   hq1_d, hq1_q;
  logic [ID_W-1:0]              r1_d, r1_q;
  logic [CODE_LEN-1:0][DIG_W-1:0] val1_d, val1_q;

  always_comb begin
    logic [ID_W-1:0]   x;
    logic [ID_W:0]     s;
    logic [CHAR_W-1:0] c;
    logic              miss;
    x = s_axis_tdata_i[ID_W-1:0] ^ XOR_MASK;
    s = {1'b0, x} + {1'b0, OFF_LO5};
    if (s >= P5_X2) begin
      hq1_d = 2'd2;
      r1_d  = 30'(s - P5_X2);
    end else if (s >= P5_X1) begin
      hq1_d = 2'd1;
      r1_d  = 30'(s - P5_X1);
    end else begin
      hq1_d = 2'd0;
      r1_d  = s[ID_W-1:0];
    end
    miss = 1'b0;
    for (int p = 0; p < CODE_LEN; p++) begin
      c = s_axis_tdata_i[ID_W + CHAR_W*p +: CHAR_W];
      val1_d[p] = char_value(c);
      miss = miss | !char_known(c);
    end
    bad1_d = s_axis_tuser_i & miss;
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      f1_q   <= s_axis_tuser_i;
      hq1_q  <= hq1_d;
      r1_q   <= r1_d;
      val1_q <= val1_d;
      bad1_q <= bad1_d;
    end
  end

  // stage 2: digit 0; weighted products
  logic                           f2_q, bad2_q;
  logic [1:0]                     hq2_q;
  logic [23:0]                    n2_q;
  logic [LO_DIGS-1:0][DIG_W-1:0]  dig2_d, dig2_q;
  logic [CODE_LEN-1:0][ID_W-1:0]  prod2_d, prod2_q;
  logic [24:0]                    q2;

  always_comb begin
    q2 = div58(r1_q);
    dig2_d = '0;
    dig2_d[0] = rem58(r1_q, q2);
    for (int p = 0; p < CODE_LEN; p++) begin
      prod2_d[p] = 30'(36'(val1_q[p]) * 36'(POS_WEIGHT[p]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      f2_q    <= f1_q;
      bad2_q  <= bad1_q;
      hq2_q   <= hq1_q;
      n2_q    <= q2[23:0];
      dig2_q  <= dig2_d;
      prod2_q <= prod2_d;
    end
  end

  // stage 3: digit 1; pair sums
  logic                           f3_q, bad3_q;
  logic [1:0]                     hq3_q;
  logic [17:0]                    n3_q;
  logic [LO_DIGS-1:0][DIG_W-1:0]  dig3_d, dig3_q;
  logic [4:0][ID_W-1:0]           sum3_d, sum3_q;
  logic [24:0]                    q3;

  always_comb begin
    q3 = div58(30'(n2_q));
    dig3_d = dig2_q;
    dig3_d[1] = rem58(30'(n2_q), q3);
    for (int i = 0; i < 5; i++) begin
      sum3_d[i] = prod2_q[2*i] + prod2_q[2*i+1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      f3_q   <= f2_q;
      bad3_q <= bad2_q;
      hq3_q  <= hq2_q;
      n3_q   <= q3[17:0];
      dig3_q <= dig3_d;
      sum3_q <= sum3_d;
    end
  end

  // stage 4: digit 2; two partial sums
  logic                           f4_q, bad4_q;
  logic [1:0]                     hq4_q;
  logic [11:0]                    n4_q;
  logic [LO_DIGS-1:0][DIG_W-1:0]  dig4_d, dig4_q;
  logic [ID_W-1:0]                sa4_q, sb4_q;
  logic [24:0]                    q4;

  always_comb begin
    q4 = div58(30'(n3_q));
    dig4_d = dig3_q;
    dig4_d[2] = rem58(30'(n3_q), q4);
  end

  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      f4_q   <= f3_q;
      bad4_q <= bad3_q;
      hq4_q  <= hq3_q;
      n4_q   <= q4[11:0];
      dig4_q <= dig4_d;
      sa4_q  <= sum3_q[0] + sum3_q[1] + sum3_q[2];
      sb4_q  <= sum3_q[3] + sum3_q[4];
    end
  end

  // stage 5: digits 3 and 4; offset removal
  b58id_mid_t mid_d, mid_q;
  logic [24:0] q5;

  always_comb begin
    q5 = div58(30'(n4_q));
    mid_d.func   = f4_q;
    mid_d.bad    = bad4_q;
    mid_d.hq     = hq4_q;
    mid_d.dig    = dig4_q;
    mid_d.dig[3] = rem58(30'(n4_q), q5);
    mid_d.dig[4] = q5[DIG_W-1:0];
    mid_d.number = (sa4_q + sb4_q - OFF_LO30) ^ XOR_MASK;
  end

  always_ff @(posedge clk_i) begin
    if (rdy5) begin
      mid_q <= mid_d;
    end
  end

  b58id_out_stage u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .mid_valid_i     (v5_q),
    .mid_ready_o     (out_rdy),
    .mid_i           (mid_q),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // carry out of the low five digits never exceeds two
  a_hq_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v5_q |-> (mid_q.hq != 2'd3))
    else $error("carry out of low digits out of range");

  // input back-pressure only when every stage is occupied
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (v1_q && v2_q && v3_q && v4_q && v5_q && m_axis_tvalid_o))
    else $error("input stalled with a bubble in the pipeline");

  // a bad-symbol flag only comes with a decode result
  a_bad_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_axis_tdata_o[109:30] == '0))
    else $error("bad-symbol flag on an encode result");

  // encode results carry no number
  a_enc_no_num: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[37:30] != '0) |->
      (m_axis_tdata_o[29:0] == '0 && !m_axis_tuser_o))
    else $error("encode result with number or flag set");

endmodule

`default_nettype wire
